@@ sv/catis_pkg.sv @@
// Shared constants for the cell array to index stream block.
package catis_pkg;

    typedef logic [1:0] cell_kind_t;

    localparam cell_kind_t KIND_VERTICES = 2'd0;
    localparam cell_kind_t KIND_LINES    = 2'd1;
    localparam cell_kind_t KIND_POLYGONS = 2'd2;
    localparam cell_kind_t KIND_STRIPS   = 2'd3;

    typedef logic [1:0] cfg_index_t;

    localparam cfg_index_t REG_CELL_KIND     = 2'd0;
    localparam cfg_index_t REG_STRIP_JOIN    = 2'd1;
    localparam cfg_index_t REG_RESTART_INDEX = 2'd2;

    localparam logic JOIN_RESTART    = 1'b0;
    localparam logic JOIN_DEGENERATE = 1'b1;

    localparam int          VALUE_W       = 32;
    localparam logic [31:0] RESTART_RESET = 32'h0000_FFFF;

endpackage

@@ sv/cell_array_to_index_stream_core.sv @@
// Top level: converts a cell connectivity array into a GPU index stream.
//
// Cell connectivity entries (a point count followed by that many point ids)
// enter one beat at a time on s_*; indices leave on m_* one beat at a time.
// An entry is parsed combinationally once it lands in the input register,
// and its zero, one or two indices go into a two-slot result register. While
// m_ready stays high, a new entry is accepted every cycle after one that
// yields one index or none; one that yields two (line segments, degenerate
// strip joins) holds the next back while both leave, one by one, on the
// one-index-wide result channel. While a result waits on m_ready the input
// register takes one more entry and then holds s_ready low.
// Configuration writes (cfg_*) are taken every cycle and must only be issued
// while the block is idle; array_start on an entry restarts the parser.
module cell_array_to_index_stream_core #(
    parameter int INDEX_BITS = 32
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // configuration writes
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  catis_pkg::cfg_index_t     cfg_index,
    input  logic [31:0]               cfg_data,
    // connectivity entries
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [31:0]               s_entry_value,
    input  logic                      s_array_start,
    // index stream
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [31:0]               m_index_out,
    output logic                      m_is_restart,
    output logic                      m_last
);
    import catis_pkg::*;

    localparam int ID_W = (INDEX_BITS < VALUE_W) ? INDEX_BITS : VALUE_W;

    // configuration
    cell_kind_t        cell_kind_reg;
    logic              strip_join_reg;
    logic [31:0]       restart_index_reg;

    // input register
    logic              in_valid_reg;
    logic [31:0]       in_value_reg;
    logic              in_start_reg;

    // parser state
    logic [31:0]       points_left_reg, points_left_next;
    logic              expect_count_reg, expect_count_next;
    logic              first_cell_reg, first_cell_next;
    logic              first_point_reg, first_point_next;
    logic [ID_W-1:0]   prev_point_reg, prev_point_next;

    // result pair register
    logic              pair_valid_reg;
    logic              pair_two_reg;
    logic              pair_sel_reg;
    logic              pair_rst_reg;
    logic [31:0]       pair_val0_reg;
    logic [31:0]       pair_val1_reg;

    // parse results
    logic              eff_expect, eff_first_cell, eff_first_point;
    logic [31:0]       eff_points;
    logic [ID_W-1:0]   eff_prev;
    logic [ID_W-1:0]   id;
    logic [31:0]       id_ext, prev_ext;
    logic [31:0]       points_dec;
    logic              emit_one, emit_two, emit_rst;
    logic [31:0]       emit_val0, emit_val1;

    logic              m_fire, pair_free, consume;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_kind_reg     <= KIND_VERTICES;
            strip_join_reg    <= JOIN_RESTART;
            restart_index_reg <= RESTART_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_CELL_KIND:     cell_kind_reg     <= cfg_data[1:0];
                REG_STRIP_JOIN:    strip_join_reg    <= cfg_data[0];
                REG_RESTART_INDEX: restart_index_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign m_fire    = m_valid && m_ready;
    assign pair_free = !pair_valid_reg || (m_fire && m_last);
    assign consume   = in_valid_reg && pair_free;
    assign s_ready   = !in_valid_reg || consume;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_value_reg <= s_entry_value;
            in_start_reg <= s_array_start;
        end
    end

    // array_start replaces the parser state by its reset values for this beat
    always_comb begin
        eff_expect      = in_start_reg || expect_count_reg;
        eff_first_cell  = in_start_reg || first_cell_reg;
        eff_first_point = in_start_reg || first_point_reg;
        eff_points      = in_start_reg ? '0 : points_left_reg;
        eff_prev        = in_start_reg ? '0 : prev_point_reg;
    end

    assign id         = in_value_reg[ID_W-1:0];
    assign id_ext     = 32'(id);
    assign prev_ext   = 32'(eff_prev);
    assign points_dec = eff_points - 32'd1;

    always_comb begin
        points_left_next  = eff_points;
        expect_count_next = eff_expect;
        first_cell_next   = eff_first_cell;
        first_point_next  = eff_first_point;
        prev_point_next   = eff_prev;
        emit_one          = 1'b0;
        emit_two          = 1'b0;
        emit_rst          = 1'b0;
        emit_val0         = id_ext;
        emit_val1         = id_ext;
        if (eff_expect) begin
            points_left_next = in_value_reg;
            first_point_next = 1'b1;
            if (cell_kind_reg == KIND_STRIPS && strip_join_reg == JOIN_RESTART &&
                !eff_first_cell) begin
                emit_one  = 1'b1;
                emit_rst  = 1'b1;
                emit_val0 = restart_index_reg;
            end
            // an empty cell closes at once
            if (in_value_reg == 32'd0) begin
                expect_count_next = 1'b1;
                first_cell_next   = 1'b0;
            end else begin
                expect_count_next = 1'b0;
            end
        end else begin
            case (cell_kind_reg)
                KIND_VERTICES: emit_one = 1'b1;
                KIND_LINES: begin
                    if (!eff_first_point) begin
                        emit_one  = 1'b1;
                        emit_two  = 1'b1;
                        emit_val0 = prev_ext;
                    end
                end
                KIND_POLYGONS: emit_one = (eff_points <= 32'd3);
                default: begin
                    emit_one = 1'b1;
                    emit_two = (strip_join_reg == JOIN_DEGENERATE) &&
                               ((eff_first_point && !eff_first_cell) ||
                                eff_points == 32'd1);
                end
            endcase
            prev_point_next  = id;
            first_point_next = 1'b0;
            points_left_next = points_dec;
            if (points_dec == 32'd0) begin
                expect_count_next = 1'b1;
                first_cell_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            points_left_reg  <= '0;
            expect_count_reg <= 1'b1;
            first_cell_reg   <= 1'b1;
            first_point_reg  <= 1'b1;
            prev_point_reg   <= '0;
        end else if (consume) begin
            points_left_reg  <= points_left_next;
            expect_count_reg <= expect_count_next;
            first_cell_reg   <= first_cell_next;
            first_point_reg  <= first_point_next;
            prev_point_reg   <= prev_point_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pair_valid_reg <= 1'b0;
            pair_sel_reg   <= 1'b0;
        end else if (consume && emit_one) begin
            pair_valid_reg <= 1'b1;
            pair_sel_reg   <= 1'b0;
        end else if (m_fire) begin
            if (m_last) begin
                pair_valid_reg <= 1'b0;
            end else begin
                pair_sel_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (consume && emit_one) begin
            pair_two_reg  <= emit_two;
            pair_rst_reg  <= emit_rst;
            pair_val0_reg <= emit_val0;
            pair_val1_reg <= emit_val1;
        end
    end

    assign m_valid      = pair_valid_reg;
    assign m_index_out  = pair_sel_reg ? pair_val1_reg : pair_val0_reg;
    assign m_is_restart = pair_rst_reg && !pair_sel_reg;
    assign m_last       = !pair_two_reg || pair_sel_reg;

endmodule

@@ sv/catis_checker.sv @@
// Port-level checks for the index stream core, bound to the top level.
module catis_checker (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  cfg_valid,
    input logic                  cfg_ready,
    input catis_pkg::cfg_index_t cfg_index,
    input logic [31:0]           cfg_data,
    input logic                  s_valid,
    input logic                  s_ready,
    input logic [31:0]           s_entry_value,
    input logic                  s_array_start,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic [31:0]           m_index_out,
    input logic                  m_is_restart,
    input logic                  m_last
);
    import catis_pkg::*;

    // a stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_index_out) &&
        $stable(m_is_restart) && $stable(m_last))
        else $error("result beat changed while stalled");

    // restart markers always stand alone
    a_rst_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_restart |-> m_last)
        else $error("restart marker not last of its entry");

    // second index of a pair follows directly
    a_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last |=> m_valid && !m_is_restart)
        else $error("second index of a pair missing");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind cell_array_to_index_stream_core catis_checker u_catis_checker (.*);

@@ tb/sv/cell_array_to_index_stream_core_tb.sv @@
// Testbench for cell_array_to_index_stream_core: connectivity entries in, checked index beats out.
module cell_array_to_index_stream_core_tb;
    import catis_pkg::*;

    localparam int          IDX_BITS      = 32;
    localparam logic [63:0] IDX_MASK      = (IDX_BITS >= 64) ? '1 : ((64'd1 << IDX_BITS) - 1);
    localparam cfg_index_t  REG_UNUSED    = 2'd3;
    localparam int          SETTLE_CYCLES = 8;

    typedef struct packed {
        logic [31:0] index;
        logic        restart;
        logic        last;
    } idx_beat_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    cfg_index_t  cfg_index;
    logic [31:0] cfg_data;
    logic        s_valid;
    logic        s_ready;
    logic [31:0] s_entry_value;
    logic        s_array_start;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_index_out;
    logic        m_is_restart;
    logic        m_last;

    // predicted configuration and parser state
    cell_kind_t  cur_kind    = KIND_VERTICES;
    logic        cur_join    = JOIN_RESTART;
    logic [31:0] cur_restart = RESTART_RESET;
    logic [31:0] pts_left    = '0;
    logic        want_count  = 1'b1;
    logic        first_cell  = 1'b1;
    logic        first_pt    = 1'b1;
    logic [31:0] prev_pt     = '0;

    idx_beat_t   idx_expect_q[$];
    idx_beat_t   want_beat;
    int          errors        = 0;
    int          entries_sent  = 0;
    bit          tx_gaps_on    = 1'b0;
    int          tx_burst_left = 0;
    bit          rx_stalls_on  = 1'b0;
    int          rx_hold_left  = 0;
    int          rx_run_left   = 0;
    logic        rx_run_state  = 1'b1;

    cell_array_to_index_stream_core #(
        .INDEX_BITS(IDX_BITS)
    ) u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_entry_value (s_entry_value),
        .s_array_start (s_array_start),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_index_out   (m_index_out),
        .m_is_restart  (m_is_restart),
        .m_last        (m_last)
    );

    initial aclk = 1'b0;
    always #4 aclk = ~aclk;

    function automatic void parser_clear();
        pts_left   = '0;
        want_count = 1'b1;
        first_cell = 1'b1;
        first_pt   = 1'b1;
        prev_pt    = '0;
    endfunction

    // Works out the index beats one accepted entry causes and queues them.
    function automatic void predict_indices(input logic [31:0] v, input logic start);
        idx_beat_t   beats[$];
        logic [31:0] id;
        if (start)
            parser_clear();
        id = 32'({32'd0, v} & IDX_MASK);
        if (want_count) begin
            pts_left = v;
            first_pt = 1'b1;
            if (cur_kind == KIND_STRIPS && cur_join == JOIN_RESTART && !first_cell)
                beats.push_back(idx_beat_t'{cur_restart, 1'b1, 1'b0});
            if (v == 0)
                first_cell = 1'b0;     // empty cell: next entry is a count again
            else
                want_count = 1'b0;
        end else begin
            case (cur_kind)
                KIND_VERTICES: begin
                    beats.push_back(idx_beat_t'{id, 1'b0, 1'b0});
                end
                KIND_LINES: begin
                    if (!first_pt) begin
                        beats.push_back(idx_beat_t'{prev_pt, 1'b0, 1'b0});
                        beats.push_back(idx_beat_t'{id, 1'b0, 1'b0});
                    end
                end
                KIND_POLYGONS: begin
                    if (pts_left <= 3)
                        beats.push_back(idx_beat_t'{id, 1'b0, 1'b0});
                end
                default: begin
                    beats.push_back(idx_beat_t'{id, 1'b0, 1'b0});
                    // degenerate join doubles the first point of a later strip and the last
                    // point of every strip; a one-point strip still gets only two copies
                    if (cur_join == JOIN_DEGENERATE &&
                        ((first_pt && !first_cell) || pts_left == 1))
                        beats.push_back(idx_beat_t'{id, 1'b0, 1'b0});
                end
            endcase
            prev_pt  = id;
            first_pt = 1'b0;
            pts_left = pts_left - 1;
            if (pts_left == 0) begin
                want_count = 1'b1;
                first_cell = 1'b0;
            end
        end
        if (beats.size() > 0)
            beats[beats.size() - 1].last = 1'b1;
        foreach (beats[i])
            idx_expect_q.push_back(beats[i]);
    endfunction

    task automatic cfg_write(input cfg_index_t idx, input logic [31:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_CELL_KIND:     cur_kind = data[1:0];
            REG_STRIP_JOIN:    cur_join = data[0];
            REG_RESTART_INDEX: cur_restart = data;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_config(input cell_kind_t kind, input logic jm, input logic [31:0] rst);
        logic [31:0] noise;
        noise = $urandom;
        cfg_write(REG_CELL_KIND, {noise[31:2], kind});
        cfg_write(REG_STRIP_JOIN, {noise[31:1], jm});
        cfg_write(REG_RESTART_INDEX, rst);
    endtask

    // One entry beat; valid stays high afterwards unless the next call opens a gap or drains results.
    task automatic send_entry(input logic [31:0] value, input logic start);
        int gap;
        gap = 0;
        if (tx_gaps_on) begin
            if (tx_burst_left == 0) begin
                gap           = $urandom_range(1, 8);
                tx_burst_left = $urandom_range(1, 16);
            end
            tx_burst_left--;
        end
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_entry_value <= value;
        s_array_start <= start;
        do @(posedge aclk); while (!s_ready);
        predict_indices(value, start);
        entries_sent++;
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (idx_expect_q.size() != 0) @(posedge aclk);
    endtask

    // entries that cause nothing may still be in flight once the queue is empty
    task automatic wait_idle();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_id();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2, 3:    return 32'($urandom_range(0, 255));
            default: return 32'($urandom);
        endcase
    endfunction

    function automatic int rand_count();
        case ($urandom_range(0, 15))
            0, 1:        return 0;
            2, 3, 4:     return 1;
            5, 6, 7:     return 2;
            8, 9:        return 3;
            10, 11, 12:  return 4;
            default:     return $urandom_range(5, 12);
        endcase
    endfunction

    task automatic send_cell(input int npts, input logic start);
        send_entry(32'(npts), start);
        for (int k = 0; k < npts; k++)
            send_entry(rand_id(), 1'b0);
    endtask

    // Mostly well-formed arrays; now and then a huge count, a restart mid-array or a stray id.
    task automatic drive_cell_traffic(input int n_entries);
        int first_sent;
        first_sent = entries_sent;
        send_cell(rand_count(), 1'b1);
        while (entries_sent - first_sent < n_entries) begin
            case ($urandom_range(0, 19))
                0:       send_entry($urandom, 1'b1);
                1:       send_cell(rand_count(), 1'b1);
                2:       send_entry(rand_id(), 1'b0);
                default: send_cell(rand_count(), 1'b0);
            endcase
        end
    endtask

    task automatic run_phase(input cell_kind_t kind, input logic jm, input logic [31:0] rst,
                             input int n_entries, input bit gaps, input bit stalls);
        wait_idle();
        set_config(kind, jm, rst);
        tx_gaps_on   = gaps;
        rx_stalls_on = stalls;
        drive_cell_traffic(n_entries);
    endtask

    task automatic test_reset_defaults();
        send_entry(32'd2, 1'b1);
        send_entry(32'h0000_0000, 1'b0);
        send_entry(32'hFFFF_FFFF, 1'b0);
        send_entry(32'd0, 1'b0);
    endtask

    task automatic test_directed_lines();
        wait_idle();
        cfg_write(REG_CELL_KIND, {30'd0, KIND_LINES});
        send_entry(32'd1, 1'b1);          // single-point line: dropped
        send_entry(32'h1234_5678, 1'b0);
        send_entry(32'd0, 1'b0);          // empty cell takes no id
        send_entry(32'd2, 1'b0);
        send_entry(32'h0000_0000, 1'b0);
        send_entry(32'hFFFF_FFFF, 1'b0);
    endtask

    task automatic test_directed_polygons();
        wait_idle();
        cfg_write(REG_CELL_KIND, {30'd0, KIND_POLYGONS});
        send_entry(32'd4, 1'b1);
        send_entry(32'hA000_0001, 1'b0);
        send_entry(32'hA000_0002, 1'b0);
        send_entry(32'hA000_0003, 1'b0);
        send_entry(32'hA000_0004, 1'b0);
        send_entry(32'd2, 1'b0);          // short polygon keeps both ids
        send_entry(32'h0000_0005, 1'b0);
        send_entry(32'h0000_0006, 1'b0);
    endtask

    task automatic test_directed_strips();
        wait_idle();
        cfg_write(REG_CELL_KIND, {30'd0, KIND_STRIPS});
        cfg_write(REG_STRIP_JOIN, {31'd0, JOIN_RESTART});
        send_entry(32'd1, 1'b1);          // first cell: no marker
        send_entry(32'h0000_0011, 1'b0);
        send_entry(32'd0, 1'b0);          // empty cell still gets a marker
        send_entry(32'd2, 1'b0);
        send_entry(32'h0000_0012, 1'b0);
        send_entry(32'h0000_0013, 1'b0);
        wait_idle();
        cfg_write(REG_STRIP_JOIN, {31'd0, JOIN_DEGENERATE});
        send_entry(32'd1, 1'b1);
        send_entry(32'h0000_0021, 1'b0);
        send_entry(32'd1, 1'b0);          // one-point strip, not first: two copies only
        send_entry(32'h0000_0022, 1'b0);
        send_entry(32'd2, 1'b0);
        send_entry(32'h0000_0023, 1'b0);
        send_entry(32'h0000_0024, 1'b0);
    endtask

    task automatic test_random_kinds();
        wait_idle();
        cfg_write(REG_UNUSED, $urandom);
        run_phase(KIND_VERTICES, JOIN_RESTART, RESTART_RESET, 80, 1'b1, 1'b1);
        run_phase(KIND_LINES, JOIN_DEGENERATE, RESTART_RESET, 90, 1'b0, 1'b1);
        run_phase(KIND_POLYGONS, JOIN_RESTART, $urandom, 80, 1'b1, 1'b0);
        run_phase(KIND_STRIPS, JOIN_RESTART, 32'h0000_0000, 80, 1'b0, 1'b0);
        run_phase(KIND_STRIPS, JOIN_RESTART, 32'hFFFF_FFFF, 70, 1'b1, 1'b1);
        run_phase(KIND_STRIPS, JOIN_DEGENERATE, $urandom, 90, 1'b1, 1'b1);
        run_phase(KIND_STRIPS, JOIN_RESTART, $urandom, 60, 1'b0, 1'b1);
    endtask

    // receiver holds off while the sender keeps offering two-index entries
    task automatic test_backpressure();
        wait_idle();
        set_config(KIND_LINES, JOIN_RESTART, RESTART_RESET);
        tx_gaps_on   = 1'b0;
        rx_stalls_on = 1'b1;
        @(posedge aclk);
        rx_hold_left = 200;
        drive_cell_traffic(60);
    endtask

    task automatic test_drain_pause();
        run_phase(KIND_STRIPS, JOIN_DEGENERATE, $urandom, 40, 1'b1, 1'b1);
        drain_results();
        drive_cell_traffic(40);
    endtask

    // receiver: long hold when asked, always ready when stalls are off, otherwise alternating ready and stall runs
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_hold_left > 0) begin
                m_ready <= 1'b0;
                rx_hold_left--;
            end else if (!rx_stalls_on) begin
                m_ready <= 1'b1;
            end else begin
                if (rx_run_left == 0) begin
                    rx_run_state = ~rx_run_state;
                    rx_run_left  = rx_run_state ? $urandom_range(1, 12) : $urandom_range(1, 6);
                end
                rx_run_left--;
                m_ready <= rx_run_state;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (idx_expect_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected index beat: expected none, %s", $time,
                         $sformatf("got index %h restart %b last %b",
                                   m_index_out, m_is_restart, m_last));
            end else begin
                want_beat = idx_expect_q.pop_front();
                if (m_index_out !== want_beat.index || m_is_restart !== want_beat.restart ||
                    m_last !== want_beat.last) begin
                    errors++;
                    $display("%0t: index beat mismatch: expected index %h restart %b last %b,%s",
                             $time, want_beat.index, want_beat.restart, want_beat.last,
                             $sformatf(" got index %h restart %b last %b",
                                       m_index_out, m_is_restart, m_last));
                end
            end
        end
    end

    initial begin
        #(8 * 400_000);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        aresetn       = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = REG_CELL_KIND;
        cfg_data      = '0;
        s_valid       = 1'b0;
        s_entry_value = '0;
        s_array_start = 1'b0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_directed_lines();
        test_directed_polygons();
        test_directed_strips();
        test_random_kinds();
        test_backpressure();
        test_drain_pause();

        wait_idle();
        repeat (20) @(posedge aclk);
        if (idx_expect_q.size() != 0) begin
            errors++;
            $display("%0t: %0d index beats never arrived", $time, idx_expect_q.size());
        end
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
